// ----- rtl/core/nnfl_pkg.sv -----
// Package for the nearest-node field lookup unit.
// Holds payload structs, register indexes, reset values and shared types.
// No dependencies.
package nnfl_pkg;

    localparam int MaxNodes = 2048;
    localparam int IdxW     = $clog2(MaxNodes);
    localparam int CntW     = IdxW + 1;
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    typedef enum logic [1:0] {
        REG_POINT_COUNT    = 2'd0,
        REG_X_OFFSET       = 2'd1,
        REG_VOLTAGE_SCALE  = 2'd2,
        REG_DISTANCE_LIMIT = 2'd3
    } reg_index_t;

    localparam logic [11:0] PointCountReset    = 12'd1851;
    localparam logic [31:0] XOffsetReset       = 32'd150994;
    localparam logic [31:0] VoltageScaleReset  = 32'd429497;
    localparam logic [63:0] DistanceLimitReset = 64'd28147497671065600;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [10:0]        index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] field_comp0;
        logic signed [31:0] field_comp1;
        logic signed [31:0] field_comp2;
        logic signed [31:0] voltage;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] field_x;
        logic signed [47:0] field_y;
        logic signed [47:0] field_z;
        logic [10:0]        nearest_index;
    } out_item_t;

    // Classified query handed from the front part to the back part.
    typedef struct packed {
        logic signed [32:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic signed [31:0] voltage;
    } query_t;

    typedef struct packed {
        logic             we;
        logic [IdxW-1:0]  addr;
        logic [31:0]      coord0;
        logic [31:0]      coord1;
        logic [31:0]      coord2;
        logic [31:0]      field0;
        logic [31:0]      field1;
        logic [31:0]      field2;
    } table_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_AMP,
        ST_MUL,
        ST_OUT
    } back_state_t;

endpackage

// ----- rtl/core/nnfl_front.sv -----
// Front part: accepts requests, writes loads into the node table and
// queues classified queries for the back part. Depends on nnfl_pkg.
module nnfl_front
    import nnfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    data_in,
    input  logic [31:0] x_offset,
    input  logic        back_busy,
    output table_wr_t   table_wr,
    output logic        q_valid,
    output query_t      q_data,
    input  logic        q_take
);

    query_t                 queue_reg [QueueDepth];
    logic [QueuePtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]     count_reg, count_next;
    logic                   queue_full;
    logic                   accept;
    logic                   is_query;
    logic                   do_take;

    // A load must not overtake a query that is still waiting or in progress.
    assign queue_full = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign full     = queue_full ||
                      ((data_in.operation == OP_LOAD) && ((count_reg != '0) || back_busy));
    assign accept   = push && !full;
    assign is_query = accept && (data_in.operation == OP_QUERY);
    assign do_take  = q_take && (count_reg != '0);
    assign q_valid  = (count_reg != '0);
    assign q_data   = queue_reg[rd_ptr_reg];

    assign table_wr.we     = accept && (data_in.operation == OP_LOAD);
    assign table_wr.addr   = data_in.index[IdxW-1:0];
    assign table_wr.coord0 = data_in.pos_x;
    assign table_wr.coord1 = data_in.pos_y;
    assign table_wr.coord2 = data_in.pos_z;
    assign table_wr.field0 = data_in.field_comp0;
    assign table_wr.field1 = data_in.field_comp1;
    assign table_wr.field2 = data_in.field_comp2;

    always_comb
    begin
        wr_ptr_next = is_query ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QueuePtrW+1)'(is_query) - (QueuePtrW+1)'(do_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            queue_reg[wr_ptr_reg].qx      <= 33'(data_in.pos_x) + 33'($signed(x_offset));
            queue_reg[wr_ptr_reg].qy      <= data_in.pos_y;
            queue_reg[wr_ptr_reg].qz      <= data_in.pos_z;
            queue_reg[wr_ptr_reg].voltage <= data_in.voltage;
        end
    end

endmodule

// ----- rtl/core/nnfl_table.sv -----
// Node table: coordinates and field components in one memory.
// One write port from the front part, one registered read port. Depends on nnfl_pkg.
module nnfl_table
    import nnfl_pkg::*;
(
    input  logic            clk,
    input  table_wr_t       table_wr,
    input  logic [IdxW-1:0] rd_addr,
    output logic [191:0]    rd_data
);

    logic [191:0] mem [MaxNodes];

    always_ff @(posedge clk)
    begin
        if (table_wr.we)
        begin
            mem[table_wr.addr] <= {table_wr.field2, table_wr.field1, table_wr.field0,
                                   table_wr.coord2, table_wr.coord1, table_wr.coord0};
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/nnfl_back.sv -----
// Back part: scans the node table for the nearest node, then scales its field.
// Holds the result register seen on the output side. Depends on nnfl_pkg.
module nnfl_back
    import nnfl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  query_t          q_data,
    output logic            q_take,
    output logic            busy,
    input  logic [11:0]     point_count,
    input  logic [31:0]     voltage_scale,
    input  logic [63:0]     distance_limit,
    output logic [IdxW-1:0] rd_addr,
    input  logic [191:0]    rd_data,
    output logic            empty,
    input  logic            pop,
    output out_item_t       data_out
);

    back_state_t        state_reg, state_next;
    query_t             query_reg;
    logic [CntW-1:0]    count_reg, count_next;
    logic [CntW-1:0]    limit;
    logic               rd_valid_reg, rd_valid_next;
    logic [IdxW-1:0]    rd_idx_reg;
    logic [IdxW-1:0]    best_i_reg, best_i_next;
    logic [63:0]        best_d_reg, best_d_next;
    logic [63:0]        sq0_reg, sq1_reg, sq2_reg;
    logic               sq_valid_reg;
    logic [IdxW-1:0]    sq_idx_reg;
    logic [63:0]        cand_d;
    logic               amp_neg_reg;
    logic [31:0]        vmag_reg;
    logic [63:0]        amp_reg;
    logic [63:0]        plo_reg [3];
    logic [63:0]        phi_reg [3];
    logic               fneg_reg [3];
    logic [47:0]        res_reg [3];
    logic               empty_reg;
    logic [IdxW-1:0]    addr_mux;

    function automatic logic [63:0] sq_sat(input logic signed [33:0] d);
        logic [33:0] mag;
        begin
            mag = d[33] ? 34'(-d) : 34'(d);
            sq_sat = (mag[33:32] != 2'b00) ? '1 : 64'(mag[31:0]) * 64'(mag[31:0]);
        end
    endfunction

    function automatic logic [64:0] add65(input logic [63:0] a, input logic [63:0] b);
        begin
            add65 = 65'(a) + 65'(b);
        end
    endfunction

    function automatic logic [47:0] finish(input logic [63:0] plo, input logic [63:0] phi,
                                          input logic neg);
        logic [64:0] t;
        logic [48:0] q;
        begin
            t = 65'(phi) + 65'(plo[63:32]) + 65'(16'h8000);
            q = (t[64:63] != 2'b00) ? 49'h0_7FFF_FFFF_FFFF : 49'(t[64:16]);
            if (q > 49'h0_7FFF_FFFF_FFFF)
            begin
                q = neg ? 49'h0_8000_0000_0000 : 49'h0_7FFF_FFFF_FFFF;
            end
            finish = neg ? 48'(-q) : 48'(q);
        end
    endfunction

    function automatic logic [31:0] fmag(input logic [31:0] f);
        begin
            fmag = f[31] ? 32'(-f) : f;
        end
    endfunction

    logic [64:0] s01, s012;
    logic [63:0] d01;
    always_comb
    begin
        s01    = add65(sq0_reg, sq1_reg);
        d01    = s01[64] ? '1 : s01[63:0];
        s012   = add65(d01, sq2_reg);
        cand_d = s012[64] ? '1 : s012[63:0];
    end

    assign limit    = (point_count > 12'(MaxNodes)) ? CntW'(MaxNodes) : CntW'(point_count);
    assign addr_mux = (state_reg == ST_SCAN) ? count_reg[IdxW-1:0] : best_i_reg;
    assign rd_addr  = addr_mux;
    assign busy     = (state_reg != ST_IDLE);
    assign empty    = empty_reg;
    assign data_out.field_x = res_reg[2];
    assign data_out.field_y = res_reg[1];
    assign data_out.field_z = res_reg[0];
    assign data_out.nearest_index = best_i_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_valid && empty_reg) state_next = ST_SCAN;
            ST_SCAN:  if (count_reg >= limit) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_valid_reg && !sq_valid_reg) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_AMP;
            ST_AMP:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_take        = (state_reg == ST_IDLE) && q_valid && empty_reg;
        count_next    = q_take ? '0 :
                        ((state_reg == ST_SCAN && count_reg < limit) ? count_reg + 1'b1
                                                                      : count_reg);
        rd_valid_next = (state_reg == ST_SCAN) && (count_reg < limit);
        best_i_next   = best_i_reg;
        best_d_next   = best_d_reg;
        if (q_take)
        begin
            best_i_next = '0;
            best_d_next = distance_limit;
        end
        else if (sq_valid_reg && cand_d < best_d_reg)
        begin
            best_i_next = sq_idx_reg;
            best_d_next = cand_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            empty_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
            sq_valid_reg <= rd_valid_reg;
            if (state_reg == ST_OUT)
            begin
                empty_reg <= 1'b0;
            end
            else if (pop)
            begin
                empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_i_reg <= best_i_next;
        best_d_reg <= best_d_next;
        rd_idx_reg <= count_reg[IdxW-1:0];
        sq_idx_reg <= rd_idx_reg;
        if (q_take)
        begin
            query_reg <= q_data;
        end
        sq0_reg <= sq_sat(34'($signed(rd_data[31:0]))   - 34'(query_reg.qz));
        sq1_reg <= sq_sat(34'($signed(rd_data[63:32]))  - 34'(query_reg.qy));
        sq2_reg <= sq_sat(34'($signed(rd_data[95:64]))  - 34'(query_reg.qx));
        if (state_reg == ST_FETCH)
        begin
            amp_neg_reg <= query_reg.voltage[31];
            vmag_reg    <= query_reg.voltage[31] ? 32'(-query_reg.voltage)
                                                 : 32'(query_reg.voltage);
        end
        if (state_reg == ST_AMP)
        begin
            amp_reg <= 64'(vmag_reg) * 64'(voltage_scale);
            for (int k = 0; k < 3; k++)
            begin
                fneg_reg[k] <= rd_data[96 + 32*k + 31];
            end
        end
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                plo_reg[k] <= 64'(amp_reg[31:0]) * 64'(fmag(rd_data[96 + 32*k +: 32]));
                phi_reg[k] <= 64'(amp_reg[62:32]) * 64'(fmag(rd_data[96 + 32*k +: 32]));
            end
        end
        if (state_reg == ST_OUT)
        begin
            for (int k = 0; k < 3; k++)
            begin
                res_reg[k] <= finish(plo_reg[k], phi_reg[k], amp_neg_reg ^ fneg_reg[k]);
            end
        end
    end

endmodule

// ----- rtl/core/nearest_node_field_lookup_unit.sv -----
// Top level of the nearest-node field lookup unit.
// Instantiates nnfl_front, nnfl_table and nnfl_back; depends on nnfl_pkg.
//
// Requests enter through push/full as a queue. A load request writes one
// node table entry in the cycle it is accepted and gives no result. A
// query request is placed in a four-entry queue and gives one result.
// Results leave through empty/pop; the oldest result is on data_out while
// empty is low.
// A query scans point_count table entries (point_count capped at 2048), one
// table entry per cycle through the single memory read port.
// Loads are accepted one per cycle while no query is queued or in progress;
// a load behind a query sees full high until that query has finished.
// Configuration is to be written through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this.
// Reset clears the queue and the state machine, marks the result register empty
// and restores the register reset values; the node table is not cleared.
// While the receiver does not pop, the result stays and the next query
// waits in the queue; once the queue is full, full is raised.
module nearest_node_field_lookup_unit
    import nnfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    data_in,
    output logic        empty,
    input  logic        pop,
    output out_item_t   data_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [11:0]     point_count_reg;
    logic [31:0]     x_offset_reg;
    logic [31:0]     voltage_scale_reg;
    logic [63:0]     distance_limit_reg;
    table_wr_t       table_wr;
    logic            q_valid;
    query_t          q_data;
    logic            q_take;
    logic            back_busy;
    logic [IdxW-1:0] rd_addr;
    logic [191:0]    rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg    <= PointCountReset;
            x_offset_reg       <= XOffsetReset;
            voltage_scale_reg  <= VoltageScaleReset;
            distance_limit_reg <= DistanceLimitReset;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_POINT_COUNT:    point_count_reg    <= cfg_data[11:0];
                REG_X_OFFSET:       x_offset_reg       <= cfg_data[31:0];
                REG_VOLTAGE_SCALE:  voltage_scale_reg  <= cfg_data[31:0];
                REG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    nnfl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_in   (data_in),
        .x_offset  (x_offset_reg),
        .back_busy (back_busy),
        .table_wr  (table_wr),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_take    (q_take)
    );

    nnfl_table u_table (
        .clk      (clk),
        .table_wr (table_wr),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    nnfl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_take         (q_take),
        .busy           (back_busy),
        .point_count    (point_count_reg),
        .voltage_scale  (voltage_scale_reg),
        .distance_limit (distance_limit_reg),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .empty          (empty),
        .pop            (pop),
        .data_out       (data_out)
    );

endmodule

// ----- rtl/core/nnfl_checker.sv -----
// Port-level checker for the nearest-node field lookup unit, bound to the top level.
// Depends on nnfl_pkg.
module nnfl_checker
    import nnfl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input out_item_t data_out
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("Result was withdrawn before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(data_out))
        else $error("Waiting result changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=> empty)
        else $error("A popped result was presented twice.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(data_out))
        else $error("Presented result holds unknown bits.");

endmodule

bind nearest_node_field_lookup_unit nnfl_checker u_nnfl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .data_out (data_out)
);
